// ===== hw/rtl/selt_pkg.sv =====
// types and codes shared by the lock table modules
package selt_pkg;

    localparam int CMD_W = 2;
    localparam int RES_W = 10;
    localparam int TXN_W = 4;
    localparam int STATUS_W = 2;
    localparam int KIND_W = 3;

    localparam logic [CMD_W-1:0] CMD_LOCK_SHARED = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOCK_EXCL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNLOCK_ALL = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_HELD = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CONFLICT = 2'd2;

    localparam logic [KIND_W-1:0] KIND_LOCK_SHARED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOCK_EXCL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UNLOCK = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNLOCK_ALL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REJECT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NOP = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [RES_W-1:0] resource;
        logic [TXN_W-1:0] transaction;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                released;
    } rsp_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [RES_W-1:0]  resource;
        logic [TXN_W-1:0]  transaction;
    } op_t;

endpackage

// ===== hw/rtl/shared_exclusive_lock_table.sv =====
// Shared/exclusive lock table with upgrade. After reset the table is cleared one entry per
// cycle, with full held high. A lock or single unlock request then takes a read and a write
// of the entry in the table sequencer (the table memory has one read and one write port); a
// request rejected for a bad resource or transaction, an unlock with a bad resource or
// transaction and an unlock-all with a bad transaction are answered from the idle state
// alone; unlock-all walks the whole table at one entry a cycle. Two-entry queues sit before
// and after the sequencer; with both queues empty a result is visible in the output queue
// right after the sequencer pushes it.
module shared_exclusive_lock_table #(
    parameter int NUM_RESOURCES = 1024,
    parameter int NUM_TX = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  selt_pkg::req_t req,
    output logic           empty,
    input  logic           pop,
    output selt_pkg::rsp_t rsp
);

    localparam int OP_W = $bits(selt_pkg::op_t);
    localparam int RSP_W = $bits(selt_pkg::rsp_t);

    logic            op_full;
    logic            op_empty;
    logic            op_push;
    logic            op_pop;
    logic            clearing;
    selt_pkg::op_t   op_in;
    selt_pkg::op_t   op_out;
    logic [OP_W-1:0] op_bits;
    logic            res_full;
    logic            res_push;
    selt_pkg::rsp_t  res;
    logic [RSP_W-1:0] rsp_bits;

    assign op_out = selt_pkg::op_t'(op_bits);
    assign rsp = selt_pkg::rsp_t'(rsp_bits);

    selt_front #(
        .NUM_RESOURCES(NUM_RESOURCES),
        .NUM_TX(NUM_TX)
    ) u_front (
        .push(push),
        .full(full),
        .req(req),
        .op_full(op_full),
        .clearing(clearing),
        .op_push(op_push),
        .op(op_in)
    );

    selt_fifo #(
        .W(OP_W)
    ) u_op_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(op_push),
        .wr_data(op_in),
        .full(op_full),
        .rd_en(op_pop),
        .rd_data(op_bits),
        .empty(op_empty)
    );

    selt_back #(
        .NUM_RESOURCES(NUM_RESOURCES),
        .NUM_TX(NUM_TX)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .op_empty(op_empty),
        .op(op_out),
        .op_pop(op_pop),
        .res_full(res_full),
        .res_push(res_push),
        .res(res),
        .clearing(clearing)
    );

    selt_fifo #(
        .W(RSP_W)
    ) u_rsp_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(res_push),
        .wr_data(res),
        .full(res_full),
        .rd_en(pop),
        .rd_data(rsp_bits),
        .empty(empty)
    );

endmodule

// ===== hw/rtl/selt_fifo.sv =====
// two-entry queue
module selt_fifo #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);

    logic [W-1:0] data_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;
    logic         do_wr;
    logic         do_rd;

    assign full = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/selt_front.sv =====
// request intake: handshake and classification into table operations
module selt_front #(
    parameter int NUM_RESOURCES = 1024,
    parameter int NUM_TX = 16
) (
    input  logic            push,
    output logic            full,
    input  selt_pkg::req_t  req,
    input  logic            op_full,
    input  logic            clearing,
    output logic            op_push,
    output selt_pkg::op_t   op
);

    logic r_ok;
    logic t_ok;

    assign r_ok = (32'(req.resource) < NUM_RESOURCES);
    assign t_ok = (32'(req.transaction) < NUM_TX);
    assign full = op_full || clearing;
    assign op_push = push && !full;

    always_comb
    begin
        op.resource = req.resource;
        op.transaction = req.transaction;
        op.kind = selt_pkg::KIND_NOP;
        unique case (req.cmd)
            selt_pkg::CMD_LOCK_SHARED:
            begin
                op.kind = (r_ok && t_ok) ? selt_pkg::KIND_LOCK_SHARED : selt_pkg::KIND_REJECT;
            end
            selt_pkg::CMD_LOCK_EXCL:
            begin
                op.kind = (r_ok && t_ok) ? selt_pkg::KIND_LOCK_EXCL : selt_pkg::KIND_REJECT;
            end
            selt_pkg::CMD_UNLOCK:
            begin
                op.kind = (r_ok && t_ok) ? selt_pkg::KIND_UNLOCK : selt_pkg::KIND_NOP;
            end
            selt_pkg::CMD_UNLOCK_ALL:
            begin
                op.kind = t_ok ? selt_pkg::KIND_UNLOCK_ALL : selt_pkg::KIND_NOP;
            end
            default:
            begin
                op.kind = selt_pkg::KIND_NOP;
            end
        endcase
    end

endmodule

// ===== hw/rtl/selt_back.sv =====
// table sequencer: entry read-modify-write, unlock-all scan, clearing pass
module selt_back #(
    parameter int NUM_RESOURCES = 1024,
    parameter int NUM_TX = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_empty,
    input  selt_pkg::op_t  op,
    output logic           op_pop,
    input  logic           res_full,
    output logic           res_push,
    output selt_pkg::rsp_t res,
    output logic           clearing
);

    localparam int AW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int CW = $clog2(NUM_RESOURCES + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;

    typedef struct packed {
        logic                      excl_valid;
        logic [selt_pkg::TXN_W-1:0] excl_owner;
        logic [NUM_TX-1:0]         shared_mask;
    } entry_t;

    entry_t mem [NUM_RESOURCES];

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    selt_pkg::op_t op_reg;
    selt_pkg::op_t op_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          pend_reg;
    logic          pend_next;
    logic [AW-1:0] wr_addr_reg;
    logic [AW-1:0] wr_addr_next;
    logic          rel_reg;
    logic          rel_next;
    entry_t        rd_data_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic [NUM_TX-1:0] tx_bit;
    logic              own_x;
    logic              other_x;
    logic              own_s;
    entry_t            drop_e;
    logic              drop_chg;
    entry_t            lock_e;
    selt_pkg::rsp_t    lock_rsp;

    assign clearing = (state_reg == ST_CLEAR);
    assign tx_bit = NUM_TX'(1) << op_reg.transaction;
    assign own_x = rd_data_reg.excl_valid && (rd_data_reg.excl_owner == op_reg.transaction);
    assign other_x = rd_data_reg.excl_valid && !own_x;
    assign own_s = ((rd_data_reg.shared_mask & tx_bit) != '0);

    // drop every hold of the request's transaction on the entry just read
    always_comb
    begin
        drop_e = rd_data_reg;
        if (own_x)
        begin
            drop_e.excl_valid = 1'b0;
            drop_e.excl_owner = '0;
        end
        if (own_s)
        begin
            drop_e.shared_mask = rd_data_reg.shared_mask & ~tx_bit;
        end
        drop_chg = own_x || own_s;
    end

    always_comb
    begin
        lock_e = rd_data_reg;
        lock_rsp.status = selt_pkg::STATUS_DONE;
        lock_rsp.released = 1'b0;
        unique case (op_reg.kind)
            selt_pkg::KIND_LOCK_SHARED:
            begin
                if (own_x || own_s)
                begin
                    lock_rsp.status = selt_pkg::STATUS_HELD;
                end
                else if (other_x)
                begin
                    lock_rsp.status = selt_pkg::STATUS_CONFLICT;
                end
                else
                begin
                    lock_e.shared_mask = rd_data_reg.shared_mask | tx_bit;
                end
            end
            selt_pkg::KIND_LOCK_EXCL:
            begin
                if (own_x)
                begin
                    lock_rsp.status = selt_pkg::STATUS_HELD;
                end
                else if (other_x || ((rd_data_reg.shared_mask & ~tx_bit) != '0))
                begin
                    lock_rsp.status = selt_pkg::STATUS_CONFLICT;
                end
                else
                begin
                    // upgrade drops the own shared bit without a release
                    lock_e.shared_mask = rd_data_reg.shared_mask & ~tx_bit;
                    lock_e.excl_valid = 1'b1;
                    lock_e.excl_owner = op_reg.transaction;
                end
            end
            default:
            begin
                lock_e = drop_e;
                lock_rsp.released = drop_chg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        cnt_next = cnt_reg;
        pend_next = pend_reg;
        wr_addr_next = wr_addr_reg;
        rel_next = rel_reg;
        op_pop = 1'b0;
        res_push = 1'b0;
        res.status = selt_pkg::STATUS_DONE;
        res.released = 1'b0;
        mem_we = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = drop_e;
        mem_re = 1'b0;
        mem_raddr = cnt_reg[AW-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = cnt_reg[AW-1:0];
                mem_wdata = '0;
                if (cnt_reg == CW'(NUM_RESOURCES - 1))
                begin
                    cnt_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_IDLE:
            begin
                if (!op_empty && !res_full)
                begin
                    op_pop = 1'b1;
                    op_next = op;
                    unique case (op.kind) inside
                        selt_pkg::KIND_LOCK_SHARED,
                        selt_pkg::KIND_LOCK_EXCL,
                        selt_pkg::KIND_UNLOCK:
                        begin
                            mem_re = 1'b1;
                            mem_raddr = AW'(op.resource);
                            state_next = ST_EXEC;
                        end
                        selt_pkg::KIND_UNLOCK_ALL:
                        begin
                            cnt_next = '0;
                            pend_next = 1'b0;
                            rel_next = 1'b0;
                            state_next = ST_SCAN;
                        end
                        selt_pkg::KIND_REJECT:
                        begin
                            res_push = 1'b1;
                            res.status = selt_pkg::STATUS_CONFLICT;
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                mem_we = 1'b1;
                mem_waddr = AW'(op_reg.resource);
                mem_wdata = lock_e;
                res_push = 1'b1;
                res = lock_rsp;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // read entry n while writing back entry n-1
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_waddr = wr_addr_reg;
                    mem_wdata = drop_e;
                    rel_next = rel_reg || drop_chg;
                end
                if (cnt_reg != CW'(NUM_RESOURCES))
                begin
                    mem_re = 1'b1;
                    mem_raddr = cnt_reg[AW-1:0];
                    wr_addr_next = cnt_reg[AW-1:0];
                    pend_next = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        res_push = 1'b1;
                        res.released = rel_reg;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg <= '0;
            pend_reg <= 1'b0;
            rel_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            pend_reg <= pend_next;
            rel_reg <= rel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        wr_addr_reg <= wr_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(mem_waddr) < NUM_RESOURCES))
        else $error("table write beyond last entry");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!op_pop && !res_push))
        else $error("request handled during clearing pass");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= CW'(NUM_RESOURCES)))
        else $error("scan counter past table end");

    a_exec_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> $past(op_pop))
        else $error("entry update without a taken request");
`endif

endmodule

// ===== dv/tb_shared_exclusive_lock_table.sv =====
// self-checking testbench for the shared/exclusive lock table
`timescale 1ns / 1ps

module tb_shared_exclusive_lock_table;

    localparam int NUM_RESOURCES = 1024;
    localparam int NUM_TX = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    selt_pkg::req_t req = '0;
    logic empty;
    logic pop = 1'b0;
    selt_pkg::rsp_t rsp;

    selt_pkg::req_t lock_requests_q[$];
    selt_pkg::rsp_t lock_answers_q[$];

    logic                       excl_valid [NUM_RESOURCES] = '{default: 1'b0};
    logic [selt_pkg::TXN_W-1:0] excl_owner [NUM_RESOURCES] = '{default: '0};
    logic [NUM_TX-1:0]          shared_mask [NUM_RESOURCES] = '{default: '0};
    logic [selt_pkg::RES_W-1:0] hot_resources [8];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int n_requests = 0;
    int n_granted = 0;
    int n_held = 0;
    int n_conflict = 0;
    int n_released = 0;
    int n_scans = 0;

    shared_exclusive_lock_table #(
        .NUM_RESOURCES(NUM_RESOURCES),
        .NUM_TX(NUM_TX)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .req(req),
        .empty(empty),
        .pop(pop),
        .rsp(rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic drop_holder(int idx, logic [selt_pkg::TXN_W-1:0] tx);
        logic changed;
        changed = 1'b0;
        if (excl_valid[idx] && excl_owner[idx] == tx)
        begin
            excl_valid[idx] = 1'b0;
            excl_owner[idx] = '0;
            changed = 1'b1;
        end
        if (shared_mask[idx][tx])
        begin
            shared_mask[idx][tx] = 1'b0;
            changed = 1'b1;
        end
        return changed;
    endfunction

    function automatic selt_pkg::rsp_t apply_lock_request(selt_pkg::req_t r);
        selt_pkg::rsp_t ans;
        int idx;
        logic res_ok;
        logic tx_ok;
        logic own_x;
        logic other_x;
        logic [NUM_TX-1:0] holder;
        ans.status = selt_pkg::STATUS_DONE;
        ans.released = 1'b0;
        idx = int'(r.resource);
        res_ok = idx < NUM_RESOURCES;
        tx_ok = int'(r.transaction) < NUM_TX;
        holder = '0;
        if (tx_ok)
            holder[r.transaction] = 1'b1;
        case (r.cmd) inside
            selt_pkg::CMD_LOCK_SHARED, selt_pkg::CMD_LOCK_EXCL:
            begin
                if (!res_ok || !tx_ok)
                    ans.status = selt_pkg::STATUS_CONFLICT;
                else
                begin
                    own_x = excl_valid[idx] && excl_owner[idx] == r.transaction;
                    other_x = excl_valid[idx] && excl_owner[idx] != r.transaction;
                    if (own_x)
                        ans.status = selt_pkg::STATUS_HELD;
                    else if (r.cmd == selt_pkg::CMD_LOCK_SHARED)
                    begin
                        if ((shared_mask[idx] & holder) != '0)
                            ans.status = selt_pkg::STATUS_HELD;
                        else if (other_x)
                            ans.status = selt_pkg::STATUS_CONFLICT;
                        else
                            shared_mask[idx] = shared_mask[idx] | holder;
                    end
                    else if (other_x || (shared_mask[idx] & ~holder) != '0)
                        ans.status = selt_pkg::STATUS_CONFLICT;
                    else
                    begin
                        // upgrade drops own shared bit without counting as a release
                        shared_mask[idx] = shared_mask[idx] & ~holder;
                        excl_valid[idx] = 1'b1;
                        excl_owner[idx] = r.transaction;
                    end
                end
            end
            selt_pkg::CMD_UNLOCK:
            begin
                if (res_ok && tx_ok)
                    ans.released = drop_holder(idx, r.transaction);
            end
            default:
            begin
                n_scans++;
                if (tx_ok)
                    for (int i = 0; i < NUM_RESOURCES; i++)
                        if (drop_holder(i, r.transaction))
                            ans.released = 1'b1;
            end
        endcase
        return ans;
    endfunction

    task automatic add_request(logic [selt_pkg::CMD_W-1:0] cmd,
                               logic [selt_pkg::RES_W-1:0] res,
                               logic [selt_pkg::TXN_W-1:0] tx);
        selt_pkg::req_t r;
        r.cmd = cmd;
        r.resource = res;
        r.transaction = tx;
        lock_requests_q = {lock_requests_q, r};
    endtask

    task automatic add_random_requests(int count);
        int k;
        int pick;
        logic [selt_pkg::TXN_W-1:0] tx;
        logic [selt_pkg::RES_W-1:0] res;
        k = 0;
        while (k < count)
        begin
            tx = selt_pkg::TXN_W'($urandom_range(NUM_TX - 1));
            if ($urandom_range(99) < 70)
                res = hot_resources[$urandom_range(7)];
            else
                res = selt_pkg::RES_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                // share, upgrade, repeat, release on one entry
                add_request(selt_pkg::CMD_LOCK_SHARED, res, tx);
                add_request(selt_pkg::CMD_LOCK_EXCL, res, tx);
                add_request(selt_pkg::CMD_LOCK_EXCL, res, tx);
                add_request(selt_pkg::CMD_UNLOCK, res, tx);
                k += 4;
            end
            else
            begin
                if (pick < 38)
                    add_request(selt_pkg::CMD_UNLOCK_ALL, res, tx);
                else if (pick < 62)
                    add_request(selt_pkg::CMD_LOCK_SHARED, res, tx);
                else if (pick < 82)
                    add_request(selt_pkg::CMD_LOCK_EXCL, res, tx);
                else
                    add_request(selt_pkg::CMD_UNLOCK, res, tx);
                k++;
            end
        end
    endtask

    task automatic drain;
        while (lock_requests_q.size() != 0 || lock_answers_q.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                lock_answers_q = {lock_answers_q, apply_lock_request(req)};
                void'(lock_requests_q.pop_front());
                n_requests++;
            end
            if (!push || !full)
            begin
                if (lock_requests_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    req <= lock_requests_q[0];
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        selt_pkg::rsp_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (lock_answers_q.size() == 0)
                begin
                    $error("result with no request waiting: status %0d released %0b",
                           rsp.status, rsp.released);
                    error_count++;
                end
                else
                begin
                    want = lock_answers_q.pop_front();
                    case (want.status)
                        selt_pkg::STATUS_DONE: n_granted++;
                        selt_pkg::STATUS_HELD: n_held++;
                        default: n_conflict++;
                    endcase
                    if (want.released)
                        n_released++;
                    if (rsp.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, rsp.status);
                        error_count++;
                    end
                    if (rsp.released !== want.released)
                    begin
                        $error("released expected %0b actual %0b", want.released,
                               rsp.released);
                        error_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        hot_resources[0] = '0;
        hot_resources[1] = '1;
        for (int i = 2; i < 8; i++)
            hot_resources[i] = selt_pkg::RES_W'($urandom);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        add_request(selt_pkg::CMD_LOCK_SHARED, 10'd0, 4'd0);
        add_request(selt_pkg::CMD_LOCK_SHARED, 10'd0, 4'd0);
        add_request(selt_pkg::CMD_LOCK_SHARED, 10'd0, 4'd15);
        add_request(selt_pkg::CMD_LOCK_EXCL, 10'd0, 4'd0);
        add_request(selt_pkg::CMD_UNLOCK, 10'd0, 4'd15);
        add_request(selt_pkg::CMD_LOCK_EXCL, 10'd0, 4'd0);
        add_request(selt_pkg::CMD_LOCK_EXCL, 10'd0, 4'd0);
        add_request(selt_pkg::CMD_LOCK_SHARED, 10'd0, 4'd0);
        add_request(selt_pkg::CMD_LOCK_SHARED, 10'd0, 4'd15);
        add_request(selt_pkg::CMD_LOCK_EXCL, 10'd0, 4'd15);
        add_request(selt_pkg::CMD_UNLOCK, 10'd0, 4'd5);
        add_request(selt_pkg::CMD_LOCK_EXCL, 10'd1023, 4'd15);
        add_request(selt_pkg::CMD_LOCK_SHARED, 10'd1023, 4'd3);
        add_request(selt_pkg::CMD_LOCK_SHARED, 10'h2AA, 4'd3);
        add_request(selt_pkg::CMD_LOCK_SHARED, 10'h155, 4'd10);
        add_request(selt_pkg::CMD_LOCK_EXCL, 10'h155, 4'd5);
        add_request(selt_pkg::CMD_LOCK_SHARED, 10'h155, 4'd3);
        add_request(selt_pkg::CMD_UNLOCK_ALL, 10'h3FF, 4'd3);
        add_request(selt_pkg::CMD_UNLOCK_ALL, 10'h000, 4'd3);
        add_request(selt_pkg::CMD_UNLOCK, 10'd0, 4'd0);
        add_request(selt_pkg::CMD_UNLOCK, 10'd1023, 4'd15);
        add_request(selt_pkg::CMD_UNLOCK_ALL, 10'h2AA, 4'd0);
        add_random_requests(220);
        drain();

        send_idle_pct = 53;
        recv_stall_pct = 0;
        add_random_requests(240);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 53;
        add_random_requests(240);
        drain();

        send_idle_pct = 19;
        recv_stall_pct = 19;
        add_random_requests(250);
        drain();

        recv_stall_pct = 0;
        repeat (50) @(posedge clk);
        $display("ran %0d requests: %0d granted or done, %0d already held, %0d conflicts",
                 n_requests, n_granted, n_held, n_conflict);
        $display("%0d requests released holds, %0d unlock-all scans", n_released, n_scans);
        if (error_count == 0)
            $display("shared_exclusive_lock_table test passed");
        else
            $display("shared_exclusive_lock_table test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d requests and %0d results outstanding",
                 lock_requests_q.size(), lock_answers_q.size());
        $display("shared_exclusive_lock_table test failed");
        $finish;
    end

endmodule
